// ----- rtl/tccw_pkg.sv -----
package tccw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CELL_W = 16;
  localparam int PEEK_W = 11;
  localparam int POS_W  = 12;

  // Key and character codes
  localparam logic [7:0] KEY_BACKSPACE = 8'h0E;
  localparam logic [7:0] KEY_LSHIFT    = 8'h2A;
  localparam logic [7:0] KEY_RSHIFT    = 8'h36;
  localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
  localparam logic [7:0] CHAR_BLANK    = 8'h20;
  localparam logic [7:0] RESET_COLOR   = 8'h03;

  typedef struct packed {
    logic              pressed;
    logic [7:0]        scancode;
    logic [7:0]        character;
    logic [PEEK_W-1:0] peek_index;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] peek_entry;
    logic              scrolled;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } ram_wr_t;

  // Map a logical row onto the ring of physical rows.
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] base,
                                                input logic [ROW_W-1:0] row);
    logic [ROW_W:0] sum;
    sum = {1'b0, base} + {1'b0, row};
    if (sum >= (ROW_W+1)'(ROWS)) sum = sum - (ROW_W+1)'(ROWS);
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(32'(prow) * COLUMNS + 32'(col));
  endfunction

endpackage

// ----- rtl/tccw_screen_ram.sv -----
module tccw_screen_ram (
  input  logic                      clk,
  input  tccw_pkg::ram_wr_t         wr,
  input  logic                      rd_en,
  input  logic [tccw_pkg::ADDR_W-1:0] rd_addr,
  output logic [tccw_pkg::CELL_W-1:0] rd_data
);
  import tccw_pkg::*;

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/tccw_peek_div.sv -----
module tccw_peek_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tccw_pkg::PEEK_W-1:0] dividend,
  output logic                        done,
  output logic [tccw_pkg::ROW_W-1:0]  quo,
  output logic [tccw_pkg::COL_W-1:0]  rem
);
  import tccw_pkg::*;

  // 205/1024 stands in for 1/5: exact for every 7-bit value divided by five.
  localparam logic [7:0] RECIP_FIVE = 8'd205;

  logic [PEEK_W-1:0] num_r;
  logic              run_r;
  logic [PEEK_W-5:0] coarse;
  logic [PEEK_W+3:0] prod;
  logic [PEEK_W-1:0] row_start;

  // Divide by a row length: drop four bits, then multiply by the reciprocal of five.
  assign coarse    = num_r[PEEK_W-1:4];
  assign prod      = (PEEK_W+4)'(coarse) * (PEEK_W+4)'(RECIP_FIVE);
  assign quo       = prod[ROW_W+9:10];
  assign row_start = PEEK_W'(32'(quo) * COLUMNS);
  assign rem       = COL_W'(num_r - row_start);
  assign done      = run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
    end
  end

endmodule

// ----- rtl/text_console_cell_writer_core.sv -----
// Sequence: an accepted item goes through EDIT, DIVGO, DIV, READ and OUT, skipping DIV when
//   peek_index lies past the screen; a scroll adds BLANK (one write per cycle blanks a row).
// Throughput: one item at a time; busy stays high until the result is produced, so the next
//   item may follow from the cycle in which out_strobe is high. The receiver cannot stall.
// Reset: synchronous, active low; a clearing pass then writes blanks to all ROWS*COLUMNS (2000)
//   cells of the screen memory while busy is high. Configuration writes are taken always.
module text_console_cell_writer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tccw_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output tccw_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  import tccw_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EDIT  = 3'd2;
  localparam logic [2:0] S_BLANK = 3'd3;
  localparam logic [2:0] S_DIVGO = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_READ  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]        state_r, state_nxt;
  in_item_t          in_r;
  logic [7:0]        color_r;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  // Physical row that holds logical row 0: a scroll just advances it.
  logic [ROW_W-1:0]  base_r, base_nxt;
  logic [ROW_W-1:0]  blank_row_r, blank_row_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              scrolled_r, scrolled_nxt;
  logic              peek_ok_r;
  out_item_t         out_r, out_nxt;
  logic              out_strobe_r;

  ram_wr_t           wr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] rd_data;

  logic              div_start;
  logic              div_done;
  logic [ROW_W-1:0]  div_quo;
  logic [COL_W-1:0]  div_rem;

  logic              accept;
  logic              need_row;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;

  assign busy       = state_r != S_IDLE;
  assign accept     = start && !busy;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;
  assign div_start  = (state_r == S_DIVGO) && peek_ok_r;
  assign col_inc    = {1'b0, col_r} + (COL_W+1)'(1);
  assign row_inc    = {1'b0, row_r} + (ROW_W+1)'(1);

  tccw_screen_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Split the peek index into logical row and column.
  tccw_peek_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_r.peek_index),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    base_nxt      = base_r;
    blank_row_nxt = blank_row_r;
    cnt_nxt       = cnt_r;
    scrolled_nxt  = scrolled_r;
    out_nxt       = out_r;
    need_row      = 1'b0;
    wr            = '0;
    rd_en         = 1'b0;
    rd_addr       = cell_addr(phys_row(base_r, div_quo), div_rem);

    unique case (state_r)
      S_CLEAR: begin
        // Sweep the whole memory with reset-colour blanks.
        wr.en   = 1'b1;
        wr.addr = cnt_r;
        wr.data = {RESET_COLOR, CHAR_BLANK};
        if (cnt_r == ADDR_W'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          state_nxt = S_EDIT;
        end
      end

      S_EDIT: begin
        scrolled_nxt = 1'b0;
        cnt_nxt      = '0;
        state_nxt    = S_DIVGO;
        if (in_r.pressed && in_r.scancode == KEY_BACKSPACE) begin
          // Backspace: step back, wrapping to the previous row; nothing at home.
          if (!(row_r == '0 && col_r == '0)) begin
            if (col_r == '0) begin
              row_nxt = row_r - ROW_W'(1);
              col_nxt = COL_W'(COLUMNS - 1);
            end else begin
              col_nxt = col_r - COL_W'(1);
            end
            wr.en   = 1'b1;
            wr.addr = cell_addr(phys_row(base_r, row_nxt), col_nxt);
            wr.data = {color_r, CHAR_BLANK};
          end
        end else if (in_r.pressed && in_r.scancode != KEY_LSHIFT &&
                     in_r.scancode != KEY_RSHIFT) begin
          if (in_r.character != CHAR_NEWLINE) begin
            // Write at the cursor and advance.
            wr.en   = 1'b1;
            wr.addr = cell_addr(phys_row(base_r, row_r), col_r);
            wr.data = {color_r, in_r.character};
            if (col_inc >= (COL_W+1)'(COLUMNS)) begin
              need_row = 1'b1;
            end else begin
              col_nxt = col_inc[COL_W-1:0];
            end
          end else begin
            need_row = 1'b1;
          end
          if (need_row) begin
            col_nxt = '0;
            if (row_inc >= (ROW_W+1)'(ROWS)) begin
              // Scroll: rotate the ring and blank the row that became the last.
              scrolled_nxt  = 1'b1;
              row_nxt       = ROW_W'(ROWS - 1);
              blank_row_nxt = base_r;
              base_nxt      = (base_r == ROW_W'(ROWS - 1)) ? '0 : base_r + ROW_W'(1);
              state_nxt     = S_BLANK;
            end else begin
              row_nxt = row_inc[ROW_W-1:0];
            end
          end
        end
      end

      S_BLANK: begin
        wr.en   = 1'b1;
        wr.addr = cell_addr(blank_row_r, cnt_r[COL_W-1:0]);
        wr.data = {color_r, CHAR_BLANK};
        if (cnt_r[COL_W-1:0] == COL_W'(COLUMNS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIVGO;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end

      S_DIVGO: begin
        // Skip the split for an out-of-range peek; its data is dropped.
        state_nxt = peek_ok_r ? S_DIV : S_READ;
      end

      S_DIV: begin
        if (div_done) begin
          state_nxt = S_READ;
        end
      end

      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        out_nxt.cursor_position = POS_W'((32'(row_r) + 1) * COLUMNS + 32'(col_r));
        out_nxt.peek_entry      = peek_ok_r ? rd_data : '0;
        out_nxt.scrolled        = scrolled_r;
        state_nxt               = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      row_r        <= '0;
      col_r        <= '0;
      base_r       <= '0;
      cnt_r        <= '0;
      scrolled_r   <= 1'b0;
      peek_ok_r    <= 1'b0;
      out_strobe_r <= 1'b0;
      color_r      <= RESET_COLOR;
    end else begin
      state_r      <= state_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      base_r       <= base_nxt;
      cnt_r        <= cnt_nxt;
      scrolled_r   <= scrolled_nxt;
      out_strobe_r <= state_r == S_OUT;
      if (accept) begin
        peek_ok_r <= 32'(in_item.peek_index) < 32'(CELLS);
      end
      if (cfg_we) begin
        color_r <= cfg_wdata;
      end
    end
  end

  // Payload registers: hold the accepted item, the row to blank and the last result.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_item;
    end
    blank_row_r <= blank_row_nxt;
    out_r       <= out_nxt;
  end

endmodule

// ----- rtl/tccw_checker.sv -----
module tccw_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input tccw_pkg::out_item_t out_item
);
  import tccw_pkg::*;

  // Reset starts the clearing pass.
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while busy");

  // A scroll leaves the cursor at the start of the last row.
  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.scrolled |-> out_item.cursor_position == POS_W'(CELLS))
    else $error("cursor not at last row after scroll");

endmodule

bind text_console_cell_writer_core tccw_checker u_tccw_checker (.*);

// ----- test/tb.sv -----
module tb;
  import tccw_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int PHASES         = 6;
  localparam int EVENTS_PER_PHASE = 108;
  // Longest path: a full row blank on a scroll, with a wide margin.
  localparam int DRAIN_CYCLES   = 5 + ROWS + COLUMNS + 40;
  localparam int MAX_REPORTED   = 40;

  typedef struct {
    in_item_t item;
    bit       aim_at_cursor;  // replace peek_index by the cell around the cursor when sent
  } key_event_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_strobe;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  // Shadow of the console: screen, cursor and current text colour.
  logic [CELL_W-1:0] shadow_screen [CELLS];
  int                cur_row;
  int                cur_col;
  logic [7:0]        text_color_shadow;

  key_event_t pending_events[$];
  out_item_t  expected_reports[$];

  bit gaps_on = 1'b1;
  int gap_left = 0;
  int n_events = 0;
  int n_reports = 0;
  int n_scrolls = 0;
  int n_erases = 0;
  int n_color_writes = 0;
  int n_errors = 0;

  text_console_cell_writer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Console predictor
  // ---------------------------------------------------------------------------

  // Advance to the next row; scroll up and blank the bottom row when already
  // on it. Return 1 when the screen scrolled.
  function automatic bit advance_row();
    cur_col = 0;
    if (cur_row + 1 >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) shadow_screen[i] = shadow_screen[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) shadow_screen[i] = {text_color_shadow, CHAR_BLANK};
      n_scrolls++;
      return 1'b1;
    end
    cur_row++;
    return 1'b0;
  endfunction

  // Apply one key event to the shadow console and return the report it gives.
  function automatic out_item_t apply_key_event(in_item_t ev);
    out_item_t rep;
    bit        rolled;
    rolled = 1'b0;
    if (ev.pressed) begin
      if (ev.scancode == KEY_BACKSPACE) begin
        // Backspace wins over any character byte; nothing happens at home.
        if (cur_row != 0 || cur_col != 0) begin
          if (cur_col == 0) begin
            // Step back onto the last column of the row above.
            cur_row--;
            cur_col = COLUMNS - 1;
          end else begin
            cur_col--;
          end
          shadow_screen[cur_row * COLUMNS + cur_col] = {text_color_shadow, CHAR_BLANK};
          n_erases++;
        end
      end else if (ev.scancode != KEY_LSHIFT && ev.scancode != KEY_RSHIFT) begin
        if (ev.character == CHAR_NEWLINE) begin
          rolled = advance_row();
        end else begin
          shadow_screen[cur_row * COLUMNS + cur_col] = {text_color_shadow, ev.character};
          cur_col++;
          if (cur_col >= COLUMNS) rolled = advance_row();
        end
      end
    end
    rep.cursor_position = POS_W'((cur_row + 1) * COLUMNS + cur_col);
    rep.peek_entry      = (ev.peek_index < CELLS) ? shadow_screen[ev.peek_index] : '0;
    rep.scrolled        = rolled;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly back-to-back items, some short pauses, the odd long one.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 30);
    return $urandom_range(60, 300);
  endfunction

  function automatic void push_event(logic p, logic [7:0] sc, logic [7:0] ch,
                                     logic [PEEK_W-1:0] peek, bit aim);
    key_event_t ev;
    ev.item.pressed    = p;
    ev.item.scancode   = sc;
    ev.item.character  = ch;
    ev.item.peek_index = peek;
    ev.aim_at_cursor   = aim;
    pending_events.push_back(ev);
  endfunction

  // Any scancode that the console treats as an ordinary key.
  function automatic logic [7:0] plain_scancode();
    logic [7:0] sc;
    do sc = 8'($urandom_range(0, 255));
    while (sc == KEY_BACKSPACE || sc == KEY_LSHIFT || sc == KEY_RSHIFT);
    return sc;
  endfunction

  function automatic logic [PEEK_W-1:0] random_peek();
    if ($urandom_range(0, 9) == 0) return PEEK_W'($urandom_range(0, 2047));
    return PEEK_W'($urandom_range(0, CELLS - 1));
  endfunction

  // Typing-like traffic: characters, newlines, erases, shifts and releases,
  // now and then a long line that wraps, plus some fully random noise.
  function automatic void queue_typing(int count);
    int         r;
    int         burst;
    logic [7:0] ch;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        burst = $urandom_range(COLUMNS, COLUMNS + 10);
        for (int b = 0; b < burst; b++)
          push_event(1'b1, plain_scancode(), 8'($urandom_range(8'h21, 8'h7E)),
                     random_peek(), 1'($urandom_range(0, 1)));
        k += burst - 1;
      end else if (r < 45) begin
        ch = 8'($urandom_range(0, 255));
        if (ch == CHAR_NEWLINE) ch = 8'h41;
        push_event(1'b1, plain_scancode(), ch, random_peek(), $urandom_range(0, 9) < 4);
      end else if (r < 60) begin
        push_event(1'b1, plain_scancode(), CHAR_NEWLINE, random_peek(), $urandom_range(0, 9) < 4);
      end else if (r < 70) begin
        push_event(1'b1, KEY_BACKSPACE, 8'($urandom_range(0, 255)), random_peek(),
                   $urandom_range(0, 9) < 5);
      end else if (r < 75) begin
        push_event(1'b1, $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT,
                   8'($urandom_range(0, 255)), random_peek(), 1'b0);
      end else if (r < 85) begin
        push_event(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   random_peek(), 1'b0);
      end else begin
        push_event(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), PEEK_W'($urandom_range(0, 2047)), 1'b0);
      end
    end
  endfunction

  // Wait until nothing is queued, presented or outstanding.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_events.size() != 0 || start || expected_reports.size() != 0);
  endtask

  task automatic write_text_color(input logic [7:0] colour);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= colour;
    @(posedge clk);
    cfg_we <= 1'b0;
    text_color_shadow = colour;
    n_color_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued items, predict each one at the edge that takes it
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_items
    key_event_t ev;
    logic       nxt_start;
    in_item_t   nxt_item;
    int         idx;
    nxt_start = start;
    nxt_item  = in_item;
    if (rst_n) begin
      if (start && !busy) begin
        // Item taken at this edge: predict its report, then hold off a while.
        expected_reports.push_back(apply_key_event(in_item));
        n_events++;
        nxt_start = 1'b0;
        gap_left  = draw_gap();
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_events.size() != 0) begin
          ev       = pending_events.pop_front();
          nxt_item = ev.item;
          if (ev.aim_at_cursor) begin
            // Point at the cell under the cursor or the one before it, where
            // this item writes or erases.
            idx = cur_row * COLUMNS + cur_col - int'($urandom_range(0, 1));
            if (idx < 0) idx = 0;
            nxt_item.peek_index = PEEK_W'(idx);
          end
          nxt_start = 1'b1;
        end
      end
    end
    // One assignment each per edge, so a held start never drops for a step.
    start   <= nxt_start;
    in_item <= nxt_item;
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every strobed report with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input int want, input int got);
    n_errors++;
    if (n_errors <= MAX_REPORTED)
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
  endtask

  always @(posedge clk) begin : check_reports
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (expected_reports.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTED)
          $display("%0t: report with nothing expected, got %h", $realtime, out_item);
      end else begin
        want = expected_reports.pop_front();
        n_reports++;
        if (out_item.cursor_position !== want.cursor_position)
          report_mismatch("cursor_position", int'(want.cursor_position),
                          int'(out_item.cursor_position));
        if (out_item.peek_entry !== want.peek_entry)
          report_mismatch("peek_entry", int'(want.peek_entry), int'(out_item.peek_entry));
        if (out_item.scrolled !== want.scrolled)
          report_mismatch("scrolled", int'(want.scrolled), int'(out_item.scrolled));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed keys, then typing phases in several colours
  // ---------------------------------------------------------------------------
  initial begin : run_phases
    logic [7:0] phase_color [PHASES];
    phase_color = '{RESET_COLOR, 8'hFF, 8'h00, 8'h5A, 8'hA5, 8'h00};
    phase_color[PHASES - 1] = 8'($urandom_range(0, 255));

    for (int i = 0; i < CELLS; i++) shadow_screen[i] = {RESET_COLOR, CHAR_BLANK};
    cur_row           = 0;
    cur_col           = 0;
    text_color_shadow = RESET_COLOR;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    // Let the clearing pass get under way, then wait for it to finish.
    repeat (3) @(posedge clk);
    while (busy) @(posedge clk);

    // Directed keys in the reset colour: release, erase at home, both shifts,
    // extreme characters and scancodes, erase carrying a newline byte, newline,
    // erase back across a row start, wrap off the last column, peeks past the
    // end of the screen and at its last cell.
    push_event(1'b0, 8'h1E, 8'h61, 11'd0, 1'b0);
    push_event(1'b1, KEY_BACKSPACE, 8'h00, 11'd0, 1'b0);
    push_event(1'b1, KEY_LSHIFT, 8'h41, 11'd0, 1'b0);
    push_event(1'b1, KEY_RSHIFT, 8'h41, 11'd0, 1'b0);
    push_event(1'b1, 8'h1E, 8'hFF, 11'd0, 1'b0);
    push_event(1'b1, 8'hFF, 8'h00, 11'd1, 1'b0);
    push_event(1'b1, 8'h00, 8'h7E, 11'd2, 1'b0);
    push_event(1'b1, KEY_BACKSPACE, CHAR_NEWLINE, 11'd2, 1'b0);
    push_event(1'b1, 8'h1C, CHAR_NEWLINE, 11'd80, 1'b0);
    push_event(1'b1, KEY_BACKSPACE, CHAR_BLANK, 11'd79, 1'b0);
    push_event(1'b1, 8'h1E, 8'h5A, 11'd79, 1'b0);
    push_event(1'b0, KEY_BACKSPACE, CHAR_NEWLINE, 11'd2047, 1'b0);
    push_event(1'b1, 8'h1E, 8'h41, 11'd2000, 1'b0);
    push_event(1'b1, 8'h1E, 8'h42, 11'd1999, 1'b0);
    push_event(1'b1, 8'h1E, 8'h80, 11'd1024, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        // Recolour only once the console has gone quiet.
        wait_idle();
        repeat (4) @(posedge clk);
        write_text_color(phase_color[ph]);
      end
      // Run two of the phases without any pauses between items.
      gaps_on = (ph != 1 && ph != 4);
      queue_typing(EVENTS_PER_PHASE);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d reports for %0d key events: %0d scrolls, %0d erases,",
             n_reports, n_events, n_scrolls, n_erases);
    $display("  across %0d text colour writes plus the reset colour.", n_color_writes);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest legal run.
  initial begin : watchdog
    #(2 * CLK_HALF * 1_000_000);
    $display("Timed out with %0d reports outstanding", expected_reports.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
